// ----- rtl/srtf_pkg.sv -----
// Package: shared types, widths and codes of the SRTF scheduler.
`timescale 1ns / 1ps
`default_nettype none

package srtf_pkg;

    localparam int DEFAULT_MAX_PROCS = 16;

    localparam int SLOT_W = 4;
    localparam int TIME_W = 16;
    localparam int CLK_W  = 24;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] arrival_time;
        logic [TIME_W-1:0] burst_time;
    } cmd_t;

    typedef struct packed {
        logic              ran;
        logic [SLOT_W-1:0] run_slot;
        logic              finished;
        logic [CLK_W-1:0]  completion_time;
        logic [CLK_W-1:0]  turnaround;
        logic [CLK_W-1:0]  waiting;
        logic [CLK_W-1:0]  current_time;
    } rsp_t;

    typedef struct packed {
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] burst;
        logic [TIME_W-1:0] remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage : srtf_pkg

`default_nettype wire

// ----- rtl/srtf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : srtf_ram

`default_nettype wire

// ----- rtl/srtf_process_scheduler.sv -----
// Top level: preemptive shortest-remaining-time-first scheduler over a slot table.
//
// A word is taken when start is high and busy is low. A load word writes one slot
// and its result is shown in the cycle after acceptance. A tick word scans the slot
// table through the single read port of the process RAM, one slot per cycle, while
// one comparator keeps the best candidate; one shared subtractor then decrements
// the chosen slot and, when it finishes, forms turnaround and waiting time in two
// more steps. The tick result is shown after the scan, drain and update states,
// also after TAT and WT on a finish; busy drops at the edge that takes the result.
// The result is shown on result for the single cycle that done is high and must
// be taken then: the receiver cannot stall. The remaining times read as zero after
// reset through per-slot valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module srtf_process_scheduler
    import srtf_pkg::*;
#(
    parameter int MAX_PROCS = DEFAULT_MAX_PROCS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t item,
    output logic      done,
    output rsp_t      result
);

    localparam int IDX_W = $clog2(MAX_PROCS);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_DRAIN  = 7'b0000100,
        ST_UPDATE = 7'b0001000,
        ST_TAT    = 7'b0010000,
        ST_WT     = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CLK_W-1:0]     time_reg, time_next;
    logic [MAX_PROCS-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic                 rd_valid_reg, rd_valid_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     best_idx_reg, best_idx_next;
    entry_t               best_reg, best_next;
    rsp_t                 res_reg, res_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    entry_t               ram_rdata;

    logic [CLK_W-1:0]     sub_a;
    logic [CLK_W-1:0]     sub_b;
    logic [CLK_W-1:0]     sub_out;
    logic                 cand;

    srtf_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_PROCS)
    ) u_proc_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(scan_cnt_reg),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        unique case (state_reg)
            ST_UPDATE:
            begin
                sub_a = CLK_W'(best_reg.remaining);
                sub_b = CLK_W'(1);
            end
            ST_TAT:
            begin
                sub_a = time_reg;
                sub_b = CLK_W'(best_reg.arrival);
            end
            ST_WT:
            begin
                sub_a = res_reg.turnaround;
                sub_b = CLK_W'(best_reg.burst);
            end
            default:
            begin
                sub_a = '0;
                sub_b = '0;
            end
        endcase
    end

    assign sub_out = sub_a - sub_b;

    assign cand = rd_pend_reg && rd_valid_reg && (ram_rdata.remaining != '0)
                  && (CLK_W'(ram_rdata.arrival) <= time_reg)
                  && (!found_reg || (ram_rdata.remaining < best_reg.remaining));

    always_comb
    begin
        state_next    = state_reg;
        time_next     = time_reg;
        valid_next    = valid_reg;
        scan_cnt_next = scan_cnt_reg;
        rd_pend_next  = 1'b0;
        rd_idx_next   = rd_idx_reg;
        rd_valid_next = rd_valid_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_next     = best_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = best_idx_reg;
        ram_wdata     = best_reg;

        if (cand)
        begin
            found_next    = 1'b1;
            best_idx_next = rd_idx_reg;
            best_next     = ram_rdata;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next              = '0;
                    res_next.current_time = time_reg;
                    if (item.mode == MODE_LOAD)
                    begin
                        if (32'(item.slot) < MAX_PROCS)
                        begin
                            ram_we                         = 1'b1;
                            ram_waddr                      = IDX_W'(item.slot);
                            ram_wdata.arrival              = item.arrival_time;
                            ram_wdata.burst                = item.burst_time;
                            ram_wdata.remaining            = item.burst_time;
                            valid_next[IDX_W'(item.slot)]  = 1'b1;
                        end
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        found_next    = 1'b0;
                        scan_cnt_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_pend_next  = 1'b1;
                rd_idx_next   = scan_cnt_reg;
                rd_valid_next = valid_reg[scan_cnt_reg];
                if (scan_cnt_reg == IDX_W'(MAX_PROCS - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                time_next             = time_reg + CLK_W'(1);
                res_next.current_time = time_reg + CLK_W'(1);
                state_next            = ST_RESP;
                if (found_reg)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.remaining = sub_out[TIME_W-1:0];
                    best_next.remaining = sub_out[TIME_W-1:0];
                    res_next.ran        = 1'b1;
                    res_next.run_slot   = SLOT_W'(best_idx_reg);
                    if (sub_out[TIME_W-1:0] == '0)
                    begin
                        res_next.finished = 1'b1;
                        state_next        = ST_TAT;
                    end
                end
            end
            ST_TAT:
            begin
                res_next.completion_time = time_reg;
                res_next.turnaround      = sub_out;
                state_next               = ST_WT;
            end
            ST_WT:
            begin
                res_next.waiting = sub_out;
                state_next       = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            time_reg    <= '0;
            valid_reg   <= '0;
            rd_pend_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            time_reg    <= time_next;
            valid_reg   <= valid_next;
            rd_pend_reg <= rd_pend_next;
            found_reg   <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_cnt_reg <= scan_cnt_next;
        rd_idx_reg   <= rd_idx_next;
        rd_valid_reg <= rd_valid_next;
        best_idx_reg <= best_idx_next;
        best_reg     <= best_next;
        res_reg      <= res_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_RESP);
    assign result = res_reg;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_finish_ran : assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.finished) |-> (result.ran && result.completion_time == time_reg))
        else $error("finish reported without a run or with wrong completion time");

    a_scan_read : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> rd_pend_reg)
        else $error("scan cycle issued no table read");

endmodule : srtf_process_scheduler

`default_nettype wire
